// ===== hw/rtl/cascaded_ema_slew_limiter_assert.svh =====
// Assertion macros used by the checker file of the command smoother.
`ifndef CASCADED_EMA_SLEW_LIMITER_ASSERT_SVH
`define CASCADED_EMA_SLEW_LIMITER_ASSERT_SVH

// Consequent must hold in the same cycle, skipped while reset is high.
`define CESL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cesl assertion failed");

// Consequent must hold in the following cycle, skipped while reset is high.
`define CESL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cesl assertion failed");

// Consequent must hold in the following cycle, checked during reset as well.
`define CESL_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("cesl assertion failed");

`endif

// ===== hw/rtl/cesl_pkg.sv =====
// Package of the command smoother: widths, register codes, reset values and types.
package cesl_pkg;

   // sample and filter level widths
   localparam int SAMPLE_W = 16;
   localparam int GUARD_W  = 8;
   localparam int LEVEL_W  = SAMPLE_W + GUARD_W;
   localparam int DIFF_W   = LEVEL_W + 1;

   // weights are Q1.16, one is 2^16
   localparam int ALPHA_W      = 17;
   localparam int ALPHA_FRAC_W = 16;
   localparam int PROD_W       = DIFF_W + ALPHA_W + 1;
   localparam int DELTA_W      = PROD_W - ALPHA_FRAC_W;
   localparam int SUM_W        = DELTA_W + 1;

   // slew bound
   localparam int RATE_W = 16;
   localparam int DT_W   = 16;
   localparam int LIM_W  = 16;

   localparam int AXES   = 4;
   localparam int AXIS_W = 2;
   localparam int STAGES = 4;

   localparam logic [AXIS_W-1:0] AXIS_HEADING = 2'd3;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
   localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(64'd1 << (ALPHA_FRAC_W - 1));
   localparam logic signed [LEVEL_W:0] GUARD_HALF = (LEVEL_W + 1)'(64'd1 << (GUARD_W - 1));

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = ALPHA_W;

   localparam logic [CSR_INDEX_W-1:0] REG_ALPHA_STAGE_ONE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ALPHA_STAGE_TWO   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ALPHA_STAGE_THREE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ALPHA_STAGE_FOUR  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_RATE_LINEAR       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_RATE_HEADING      = 3'd5;

   localparam logic [STAGES-1:0][ALPHA_W-1:0] ALPHA_RESET =
      {17'd6554, 17'd13107, 17'd19661, 17'd26214};
   localparam logic [RATE_W-1:0] RATE_LINEAR_RESET  = 16'd512;
   localparam logic [RATE_W-1:0] RATE_HEADING_RESET = 16'd384;

   // stream bus widths
   localparam int REQ_DATA_W = AXES * SAMPLE_W + DT_W;
   localparam int RSP_DATA_W = AXES * SAMPLE_W;

   // one axis value moving down the cell chain
   typedef struct packed {
      logic                      valid;
      logic [AXIS_W-1:0]         axis;
      logic signed [LEVEL_W-1:0] value;
   } lane_type;

   // slew cell completion
   typedef struct packed {
      logic              valid;
      logic [AXIS_W-1:0] axis;
   } done_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FEED,
      ST_DRAIN,
      ST_HOLD
   } state_type;

endpackage

// ===== hw/rtl/cesl_filter_cell.sv =====
// One low-pass stage of the chain: holds the level of every axis for its stage.
module cesl_filter_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [cesl_pkg::ALPHA_W-1:0]       alpha,
   input  cesl_pkg::lane_type                 lane_in,
   output cesl_pkg::lane_type                 lane_out
);

   localparam logic signed [cesl_pkg::LEVEL_W-1:0] LEVEL_MAX =
      {1'b0, {(cesl_pkg::LEVEL_W - 1){1'b1}}};
   localparam logic signed [cesl_pkg::LEVEL_W-1:0] LEVEL_MIN =
      {1'b1, {(cesl_pkg::LEVEL_W - 1){1'b0}}};

   logic signed [cesl_pkg::LEVEL_W-1:0] level_ff [cesl_pkg::AXES];

   // difference stage
   logic                                valid_a_ff;
   logic [cesl_pkg::AXIS_W-1:0]         axis_a_ff;
   logic signed [cesl_pkg::LEVEL_W-1:0] level_a_ff;
   logic signed [cesl_pkg::DIFF_W-1:0]  diff_a_ff;
   logic signed [cesl_pkg::LEVEL_W-1:0] level_a_in;
   logic signed [cesl_pkg::DIFF_W-1:0]  diff_a_in;

   // product stage
   logic                                valid_b_ff;
   logic [cesl_pkg::AXIS_W-1:0]         axis_b_ff;
   logic signed [cesl_pkg::LEVEL_W-1:0] level_b_ff;
   logic signed [cesl_pkg::PROD_W-1:0]  prod_b_ff;
   logic signed [cesl_pkg::PROD_W-1:0]  prod_b_in;
   logic [cesl_pkg::ALPHA_W-1:0]        alpha_eff;

   // update stage
   logic signed [cesl_pkg::PROD_W-1:0]  round_c;
   logic [cesl_pkg::DELTA_W-1:0]        delta_c;
   logic signed [cesl_pkg::SUM_W-1:0]   sum_c;
   logic signed [cesl_pkg::LEVEL_W-1:0] level_c_in;
   cesl_pkg::lane_type                  lane_out_ff;

   // weight above one acts as one
   assign alpha_eff = (alpha > cesl_pkg::ALPHA_ONE) ? cesl_pkg::ALPHA_ONE : alpha;

   always_comb begin
      level_a_in = level_ff[lane_in.axis];
      diff_a_in  = $signed({lane_in.value[cesl_pkg::LEVEL_W-1], lane_in.value})
                 - $signed({level_a_in[cesl_pkg::LEVEL_W-1], level_a_in});
   end

   assign prod_b_in = diff_a_ff * $signed({1'b0, alpha_eff});

   // round half up, add to level, saturate
   always_comb begin
      round_c = prod_b_ff + cesl_pkg::PROD_HALF;
      delta_c = round_c[cesl_pkg::PROD_W-1:cesl_pkg::ALPHA_FRAC_W];
      sum_c   = $signed({{(cesl_pkg::SUM_W - cesl_pkg::LEVEL_W){level_b_ff[cesl_pkg::LEVEL_W-1]}},
                         level_b_ff})
              + $signed({delta_c[cesl_pkg::DELTA_W-1], delta_c});
      if (sum_c > $signed({{(cesl_pkg::SUM_W - cesl_pkg::LEVEL_W){1'b0}}, LEVEL_MAX})) begin
         level_c_in = LEVEL_MAX;
      end else if (sum_c < $signed({{(cesl_pkg::SUM_W - cesl_pkg::LEVEL_W){1'b1}}, LEVEL_MIN}))
      begin
         level_c_in = LEVEL_MIN;
      end else begin
         level_c_in = sum_c[cesl_pkg::LEVEL_W-1:0];
      end
   end

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff        <= 1'b0;
         valid_b_ff        <= 1'b0;
         lane_out_ff.valid <= 1'b0;
      end else begin
         valid_a_ff        <= lane_in.valid;
         valid_b_ff        <= valid_a_ff;
         lane_out_ff.valid <= valid_b_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      axis_a_ff         <= lane_in.axis;
      level_a_ff        <= level_a_in;
      diff_a_ff         <= diff_a_in;
      axis_b_ff         <= axis_a_ff;
      level_b_ff        <= level_a_ff;
      prod_b_ff         <= prod_b_in;
      lane_out_ff.axis  <= axis_b_ff;
      lane_out_ff.value <= level_c_in;
   end

   // per-axis levels of this stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cesl_pkg::AXES; i++) begin
            level_ff[i] <= '0;
         end
      end else if (valid_b_ff) begin
         level_ff[axis_b_ff] <= level_c_in;
      end
   end

   assign lane_out = lane_out_ff;

endmodule

// ===== hw/rtl/cesl_slew_cell.sv =====
// Last cell of the chain: rounds the filtered level and limits its change per step.
module cesl_slew_cell (
   input  logic                                               clock,
   input  logic                                               reset,
   input  cesl_pkg::lane_type                                 lane_in,
   input  logic [cesl_pkg::LIM_W-1:0]                         max_linear,
   input  logic [cesl_pkg::LIM_W-1:0]                         max_heading,
   output cesl_pkg::done_type                                 done,
   output logic [cesl_pkg::AXES-1:0][cesl_pkg::SAMPLE_W-1:0]  limited
);

   localparam int SW = cesl_pkg::SAMPLE_W;
   localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW - 1){1'b1}}};
   localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW - 1){1'b0}}};

   logic [cesl_pkg::AXES-1:0][SW-1:0] limited_ff;

   // rounding stage
   logic signed [cesl_pkg::LEVEL_W:0] rnd_a;
   logic [SW:0]                       tgt_wide_a;
   logic signed [SW-1:0]              target_a_in;
   logic signed [SW-1:0]              target_a_ff;
   logic                              valid_a_ff;
   logic [cesl_pkg::AXIS_W-1:0]       axis_a_ff;

   // change stage
   logic signed [SW-1:0]              cur_b_in;
   logic signed [SW:0]                change_b_in;
   logic [cesl_pkg::LIM_W-1:0]        lim_b_in;
   logic signed [SW-1:0]              cur_b_ff;
   logic signed [SW:0]                change_b_ff;
   logic [cesl_pkg::LIM_W-1:0]        lim_b_ff;
   logic                              valid_b_ff;
   logic [cesl_pkg::AXIS_W-1:0]       axis_b_ff;

   // clamp and add stage
   logic signed [SW+1:0]              lim_pos_c;
   logic signed [SW+1:0]              lim_neg_c;
   logic signed [SW+1:0]              change_c;
   logic signed [SW+1:0]              clamped_c;
   logic signed [SW+1:0]              sum_c;
   logic signed [SW-1:0]              limited_c_in;
   cesl_pkg::done_type                done_ff;

   // round half up by the guard bits, saturate to sample width
   always_comb begin
      rnd_a      = $signed({lane_in.value[cesl_pkg::LEVEL_W-1], lane_in.value})
                 + cesl_pkg::GUARD_HALF;
      tgt_wide_a = rnd_a[cesl_pkg::LEVEL_W:cesl_pkg::GUARD_W];
      if (tgt_wide_a[SW] != tgt_wide_a[SW-1]) begin
         target_a_in = tgt_wide_a[SW] ? SAMPLE_MIN : SAMPLE_MAX;
      end else begin
         target_a_in = tgt_wide_a[SW-1:0];
      end
   end

   // change toward target, bound per axis group
   always_comb begin
      cur_b_in    = limited_ff[axis_a_ff];
      change_b_in = $signed({target_a_ff[SW-1], target_a_ff})
                  - $signed({cur_b_in[SW-1], cur_b_in});
      lim_b_in    = (axis_a_ff == cesl_pkg::AXIS_HEADING) ? max_heading : max_linear;
   end

   // clamp to [-lim, lim] and apply
   always_comb begin
      lim_pos_c = $signed({2'b00, lim_b_ff});
      lim_neg_c = -lim_pos_c;
      change_c  = $signed({change_b_ff[SW], change_b_ff});
      if (change_c > lim_pos_c) begin
         clamped_c = lim_pos_c;
      end else if (change_c < lim_neg_c) begin
         clamped_c = lim_neg_c;
      end else begin
         clamped_c = change_c;
      end
      sum_c = $signed({{2{cur_b_ff[SW-1]}}, cur_b_ff}) + clamped_c;
      if (sum_c > $signed({2'b00, SAMPLE_MAX})) begin
         limited_c_in = SAMPLE_MAX;
      end else if (sum_c < $signed({2'b11, SAMPLE_MIN})) begin
         limited_c_in = SAMPLE_MIN;
      end else begin
         limited_c_in = sum_c[SW-1:0];
      end
   end

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff    <= 1'b0;
         valid_b_ff    <= 1'b0;
         done_ff.valid <= 1'b0;
      end else begin
         valid_a_ff    <= lane_in.valid;
         valid_b_ff    <= valid_a_ff;
         done_ff.valid <= valid_b_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      axis_a_ff    <= lane_in.axis;
      target_a_ff  <= target_a_in;
      axis_b_ff    <= axis_a_ff;
      cur_b_ff     <= cur_b_in;
      change_b_ff  <= change_b_in;
      lim_b_ff     <= lim_b_in;
      done_ff.axis <= axis_b_ff;
   end

   // limited output per axis
   always_ff @(posedge clock) begin
      if (reset) begin
         limited_ff <= '0;
      end else if (valid_b_ff) begin
         limited_ff[axis_b_ff] <= limited_c_in;
      end
   end

   assign done    = done_ff;
   assign limited = limited_ff;

endmodule

// ===== hw/rtl/cascaded_ema_slew_limiter.sv =====
// Top level of the four-axis command smoother: control, registers and the cell chain.
//
// Input channel req_*: one word carries vel_x, vel_y, vel_z, vel_heading and
// step_time. Output channel rsp_*: one word carries out_x, out_y, out_z and
// out_heading. Every accepted input word gives exactly one output word.
// Configuration: csr_we with csr_index and csr_wdata writes one register;
// the user must write only while the block is idle; the block does not enforce it.
// Inside, the four axes enter one per cycle into a chain of four filter
// cells (difference, product and update stages each) and a slew cell
// (rounding, change, and clamp and add stages). The result word is loaded
// into the output register when the heading axis leaves the slew cell,
// and no new word is taken until the block is idle again.
// req_tready is high only while the block is idle. A result waiting in the
// output register does not block the next input; a second result that
// finishes while the first is still stalled waits inside until rsp_tready.
// Reset (synchronous, active high) clears every filter level and limited
// output to zero and loads the default weights and rates.
module cascaded_ema_slew_limiter (
   input  logic                                  clock,
   input  logic                                  reset,
   // vel_x [15:0], vel_y [31:16], vel_z [47:32], vel_heading [63:48],
   // step_time [79:64]
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [cesl_pkg::REQ_DATA_W-1:0]       req_tdata,
   // out_x [15:0], out_y [31:16], out_z [47:32], out_heading [63:48]
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [cesl_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_we,
   input  logic [cesl_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [cesl_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int SW   = cesl_pkg::SAMPLE_W;
   localparam int PRDW = cesl_pkg::RATE_W + cesl_pkg::DT_W;

   // configuration registers
   logic [cesl_pkg::STAGES-1:0][cesl_pkg::ALPHA_W-1:0] alpha_ff;
   logic [cesl_pkg::STAGES-1:0][cesl_pkg::ALPHA_W-1:0] alpha_in;
   logic [cesl_pkg::RATE_W-1:0] rate_linear_ff;
   logic [cesl_pkg::RATE_W-1:0] rate_linear_in;
   logic [cesl_pkg::RATE_W-1:0] rate_heading_ff;
   logic [cesl_pkg::RATE_W-1:0] rate_heading_in;

   // control
   cesl_pkg::state_type         state_ff;
   cesl_pkg::state_type         state_in;
   logic [cesl_pkg::AXIS_W-1:0] feed_ff;
   logic [cesl_pkg::AXIS_W-1:0] feed_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic                        rsp_load;
   logic                        req_accept;

   // captured word
   logic [cesl_pkg::AXES-1:0][SW-1:0] sample_ff;
   logic [cesl_pkg::LIM_W-1:0]        max_linear_ff;
   logic [cesl_pkg::LIM_W-1:0]        max_heading_ff;
   logic [PRDW-1:0]                   prod_linear;
   logic [PRDW-1:0]                   prod_heading;
   logic [cesl_pkg::RSP_DATA_W-1:0]   rsp_data_ff;

   // chain
   cesl_pkg::lane_type                chain [cesl_pkg::STAGES+1];
   cesl_pkg::done_type                slew_done;
   logic [cesl_pkg::AXES-1:0][SW-1:0] limited;

   // register writes; unknown indexes are dropped
   always_comb begin
      alpha_in        = alpha_ff;
      rate_linear_in  = rate_linear_ff;
      rate_heading_in = rate_heading_ff;
      if (csr_we) begin
         case (csr_index)
            cesl_pkg::REG_ALPHA_STAGE_ONE:   alpha_in[0] = csr_wdata;
            cesl_pkg::REG_ALPHA_STAGE_TWO:   alpha_in[1] = csr_wdata;
            cesl_pkg::REG_ALPHA_STAGE_THREE: alpha_in[2] = csr_wdata;
            cesl_pkg::REG_ALPHA_STAGE_FOUR:  alpha_in[3] = csr_wdata;
            cesl_pkg::REG_RATE_LINEAR:  rate_linear_in  = csr_wdata[cesl_pkg::RATE_W-1:0];
            cesl_pkg::REG_RATE_HEADING: rate_heading_in = csr_wdata[cesl_pkg::RATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff        <= cesl_pkg::ALPHA_RESET;
         rate_linear_ff  <= cesl_pkg::RATE_LINEAR_RESET;
         rate_heading_ff <= cesl_pkg::RATE_HEADING_RESET;
      end else begin
         alpha_ff        <= alpha_in;
         rate_linear_ff  <= rate_linear_in;
         rate_heading_ff <= rate_heading_in;
      end
   end

   assign req_tready = (state_ff == cesl_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // slew bounds in sample LSBs
   assign prod_linear  = rate_linear_ff  * req_tdata[cesl_pkg::REQ_DATA_W-1:cesl_pkg::AXES*SW];
   assign prod_heading = rate_heading_ff * req_tdata[cesl_pkg::REQ_DATA_W-1:cesl_pkg::AXES*SW];

   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_ff      <= req_tdata[cesl_pkg::AXES*SW-1:0];
         max_linear_ff  <= prod_linear[PRDW-1:cesl_pkg::DT_W];
         max_heading_ff <= prod_heading[PRDW-1:cesl_pkg::DT_W];
      end
   end

   // next state, feed counter and output load
   always_comb begin
      state_in     = state_ff;
      feed_in      = feed_ff;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         cesl_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = cesl_pkg::ST_FEED;
               feed_in  = '0;
            end
         end
         cesl_pkg::ST_FEED: begin
            feed_in = feed_ff + 1'b1;
            if (feed_ff == cesl_pkg::AXIS_HEADING) begin
               state_in = cesl_pkg::ST_DRAIN;
            end
         end
         cesl_pkg::ST_DRAIN: begin
            if (slew_done.valid && slew_done.axis == cesl_pkg::AXIS_HEADING) begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_load = 1'b1;
                  state_in = cesl_pkg::ST_IDLE;
               end else begin
                  state_in = cesl_pkg::ST_HOLD;
               end
            end
         end
         cesl_pkg::ST_HOLD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = cesl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cesl_pkg::ST_IDLE;
         end
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cesl_pkg::ST_IDLE;
         feed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         feed_ff      <= feed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= limited;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // one axis per cycle into the chain, widened by the guard bits
   always_comb begin
      chain[0].valid = (state_ff == cesl_pkg::ST_FEED);
      chain[0].axis  = feed_ff;
      chain[0].value = {sample_ff[feed_ff], {cesl_pkg::GUARD_W{1'b0}}};
   end

   for (genvar s = 0; s < cesl_pkg::STAGES; s++) begin : g_stage
      cesl_filter_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .alpha    (alpha_ff[s]),
         .lane_in  (chain[s]),
         .lane_out (chain[s+1])
      );
   end

   cesl_slew_cell u_slew (
      .clock       (clock),
      .reset       (reset),
      .lane_in     (chain[cesl_pkg::STAGES]),
      .max_linear  (max_linear_ff),
      .max_heading (max_heading_ff),
      .done        (slew_done),
      .limited     (limited)
   );

endmodule

// ===== hw/rtl/cesl_checker.sv =====
// Port-level checks of the command smoother and their binding to the top level.
`include "cascaded_ema_slew_limiter_assert.svh"

module cesl_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [cesl_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   // reset empties the output register
   `CESL_ASSERT_NEXT_ALWAYS(a_reset_clears_rsp, clock, reset, !rsp_tvalid)

   // a stalled result word holds
   `CESL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // one word in the chain at a time
   `CESL_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)

   // no result can be ready the cycle after a word enters
   `CESL_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_tvalid && req_tready, !$rose(rsp_tvalid))

endmodule

bind cascaded_ema_slew_limiter cesl_checker u_cesl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
